// File: sv/spq_pkg.sv
// shared constants, types and command struct for the sorted priority queue
// used by spq_ctrl, spq_datapath and sorted_priority_queue
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int PRI_W    = 8;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} dp_cmd_t;

endpackage

// File: sv/spq_ctrl.sv
// handshake controller of the sorted priority queue
// depends on spq_pkg; drives spq_datapath through dp_cmd_t
module spq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output spq_pkg::dp_cmd_t cmd
);
	import spq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        rsp_full_q;

	assign req_ready   = (state_q == ST_IDLE) && (!rsp_full_q || rsp_ready);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign rsp_valid   = rsp_full_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rsp_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_full_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_full_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/spq_datapath.sv
// shifting cell chain holding the sorted entries, request capture and result registers
// depends on spq_pkg; commanded by spq_ctrl
module spq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spq_pkg::dp_cmd_t                 cmd,
	input  logic                             req_type,
	input  logic signed [spq_pkg::VAL_W-1:0] item_value,
	input  logic        [spq_pkg::PRI_W-1:0] item_priority,
	output logic                             out_valid,
	output logic signed [spq_pkg::VAL_W-1:0] out_value,
	output logic                             underflow,
	output logic                             overflow
);
	import spq_pkg::*;

	logic                    in_type_q;
	logic signed [VAL_W-1:0] in_val_q;
	logic        [PRI_W-1:0] in_pri_q;

	logic signed [VAL_W-1:0] cell_val_q [CAPACITY];
	logic        [PRI_W-1:0] cell_pri_q [CAPACITY];
	logic signed [VAL_W-1:0] cell_val_d [CAPACITY];
	logic        [PRI_W-1:0] cell_pri_d [CAPACITY];
	logic        [CNT_W-1:0] count_q;
	logic        [CNT_W-1:0] count_d;

	logic        [CAPACITY-1:0] le;
	logic        [CAPACITY-1:0] prev_le;
	logic signed [VAL_W-1:0]    prev_val [CAPACITY];
	logic        [PRI_W-1:0]    prev_pri [CAPACITY];
	logic signed [VAL_W-1:0]    next_val [CAPACITY];
	logic        [PRI_W-1:0]    next_pri [CAPACITY];

	logic                    full;
	logic                    empty;
	logic                    do_ins;
	logic                    do_del;
	logic                    res_valid_d;
	logic signed [VAL_W-1:0] res_value_d;
	logic                    res_under_d;
	logic                    res_over_d;

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign do_ins = cmd.exec && (in_type_q == REQ_INSERT) && !full;
	assign do_del = cmd.exec && (in_type_q == REQ_DELETE) && !empty;

	// per-cell compare and neighbor taps
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(g);
		assign le[g] = (CELL_IDX < count_q) && (cell_pri_q[g] <= in_pri_q);
		if (g == 0) begin : g_first
			assign prev_le[g]  = 1'b1;
			assign prev_val[g] = in_val_q;
			assign prev_pri[g] = in_pri_q;
		end else begin : g_rest
			assign prev_le[g]  = le[g-1];
			assign prev_val[g] = cell_val_q[g-1];
			assign prev_pri[g] = cell_pri_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_val[g] = cell_val_q[g];
			assign next_pri[g] = cell_pri_q[g];
		end else begin : g_mid
			assign next_val[g] = cell_val_q[g+1];
			assign next_pri[g] = cell_pri_q[g+1];
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_val_d[i] = cell_val_q[i];
			cell_pri_d[i] = cell_pri_q[i];
			if (do_ins && !le[i]) begin
				if (prev_le[i]) begin
					cell_val_d[i] = in_val_q;
					cell_pri_d[i] = in_pri_q;
				end else begin
					cell_val_d[i] = prev_val[i];
					cell_pri_d[i] = prev_pri[i];
				end
			end else if (do_del) begin
				cell_val_d[i] = next_val[i];
				cell_pri_d[i] = next_pri[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		res_valid_d = 1'b0;
		res_value_d = '0;
		res_under_d = 1'b0;
		res_over_d  = 1'b0;
		if (in_type_q == REQ_INSERT) begin
			res_over_d = full;
		end else if (empty) begin
			res_under_d = 1'b1;
		end else begin
			res_valid_d = 1'b1;
			res_value_d = cell_val_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_type_q <= req_type;
			in_val_q  <= item_value;
			in_pri_q  <= item_priority;
		end
		if (cmd.exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				cell_val_q[i] <= cell_val_d[i];
				cell_pri_q[i] <= cell_pri_d[i];
			end
			out_valid <= res_valid_d;
			out_value <= res_value_d;
			underflow <= res_under_d;
			overflow  <= res_over_d;
		end
	end

endmodule

// File: sv/sorted_priority_queue.sv
// top level of the sorted priority queue: controller plus cell-chain datapath
// depends on spq_pkg, spq_ctrl and spq_datapath
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  request | req_valid/req_ready  | req_type, item_value, item_priority
//  result  | rsp_valid/rsp_ready  | out_valid, out_value, underflow, overflow
//
// each request is first captured into the input registers, then the cell chain
// compares all entries in parallel and shifts in or out
// the result register is free again when rsp_ready is high, so a new item can be
// taken in the same cycle as the previous result leaves
// reset clears the entry count and control state; cell contents are not reset
module sorted_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             req_type,
	input  logic signed [spq_pkg::VAL_W-1:0] item_value,
	input  logic        [spq_pkg::PRI_W-1:0] item_priority,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             out_valid,
	output logic signed [spq_pkg::VAL_W-1:0] out_value,
	output logic                             underflow,
	output logic                             overflow
);
	import spq_pkg::*;

	dp_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	spq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_type      (req_type),
		.item_value    (item_value),
		.item_priority (item_priority),
		.out_valid     (out_valid),
		.out_value     (out_value),
		.underflow     (underflow),
		.overflow      (overflow)
	);

endmodule

// File: tb/sv/spq_checker.sv
`timescale 1ns / 100ps
// checker for the sorted priority queue: watches both channels, keeps its own
// sorted copy of the entries, predicts every result and compares it on arrival
// depends on spq_pkg for the widths, the capacity and the request codes
module spq_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  logic                             req_type,
	input  logic signed [spq_pkg::VAL_W-1:0] item_value,
	input  logic        [spq_pkg::PRI_W-1:0] item_priority,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic                             out_valid,
	input  logic signed [spq_pkg::VAL_W-1:0] out_value,
	input  logic                             underflow,
	input  logic                             overflow,
	output int                               fail_count,
	output int                               pending,
	output int                               pops_seen,
	output int                               underflows_seen,
	output int                               overflows_seen
);
	import spq_pkg::*;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		logic             under;
		logic             over;
	} spq_result_t;

	logic [VAL_W-1:0] held_value [CAPACITY];
	logic [PRI_W-1:0] held_pri [CAPACITY];
	int               held_count;
	spq_result_t      expected_results [$];
	int               errors;
	int               n_pop;
	int               n_under;
	int               n_over;

	function automatic spq_result_t queue_apply(input logic kind,
			input logic [VAL_W-1:0] v, input logic [PRI_W-1:0] p);
		spq_result_t r;
		int          slot;
		int          i;
		r = '0;
		if (kind == REQ_INSERT) begin
			if (held_count >= CAPACITY) begin
				r.over = 1'b1;
			end else begin
				slot = 0;
				while (slot < held_count && held_pri[slot] <= p)
					slot++;
				for (i = held_count; i > slot; i--) begin
					held_value[i] = held_value[i-1];
					held_pri[i]   = held_pri[i-1];
				end
				held_value[slot] = v;
				held_pri[slot]   = p;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.under = 1'b1;
			end else begin
				r.valid = 1'b1;
				r.value = held_value[0];
				for (i = 1; i < held_count; i++) begin
					held_value[i-1] = held_value[i];
					held_pri[i-1]   = held_pri[i];
				end
				held_count--;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		spq_result_t want;
		spq_result_t got;
		if (!arst_n) begin
			held_count = 0;
			expected_results.delete();
			errors  = 0;
			n_pop   = 0;
			n_under = 0;
			n_over  = 0;
		end else begin
			if (req_valid && req_ready)
				expected_results.push_back(queue_apply(req_type, item_value, item_priority));
			if (rsp_valid && rsp_ready) begin
				got = '{out_valid, out_value, underflow, overflow};
				n_pop   += int'(got.valid);
				n_under += int'(got.under);
				n_over  += int'(got.over);
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with no item pending: valid %0b value %0d under %0b over %0b",
						$time, got.valid, $signed(got.value), got.under, got.over);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected valid %0b value %0d under %0b over %0b",
							$time, want.valid, $signed(want.value), want.under, want.over);
						$display("%0t:   actual valid %0b value %0d under %0b over %0b",
							$time, got.valid, $signed(got.value), got.under, got.over);
					end
				end
			end
		end
		fail_count      <= errors;
		pending         <= expected_results.size();
		pops_seen       <= n_pop;
		underflows_seen <= n_under;
		overflows_seen  <= n_over;
	end

endmodule

// File: tb/sv/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// testbench top for the sorted priority queue: clock, reset, item stimulus,
// a receiver with random and long stalls, and the final verdict
// depends on spq_pkg, sorted_priority_queue and spq_checker
module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int ITEM_TARGET = 1650;
	localparam int HOLD_LEN    = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {
		RSP_RANDOM,
		RSP_ALWAYS,
		RSP_HOLD
	} rsp_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_ready;
	logic                    req_type;
	logic signed [VAL_W-1:0] item_value;
	logic        [PRI_W-1:0] item_priority;
	logic                    rsp_valid;
	logic                    rsp_ready;
	logic                    out_valid;
	logic signed [VAL_W-1:0] out_value;
	logic                    underflow;
	logic                    overflow;

	int        fail_count;
	int        pending;
	int        pops_seen;
	int        underflows_seen;
	int        overflows_seen;
	int        items_sent;
	int        cycles;
	int        hold_cycles;
	bit        sender_idles;
	rsp_mode_t rsp_mode;

	sorted_priority_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_type      (req_type),
		.item_value    (item_value),
		.item_priority (item_priority),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.out_valid     (out_valid),
		.out_value     (out_value),
		.underflow     (underflow),
		.overflow      (overflow)
	);

	spq_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req_type        (req_type),
		.item_value      (item_value),
		.item_priority   (item_priority),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.out_valid       (out_valid),
		.out_value       (out_value),
		.underflow       (underflow),
		.overflow        (overflow),
		.fail_count      (fail_count),
		.pending         (pending),
		.pops_seen       (pops_seen),
		.underflows_seen (underflows_seen),
		.overflows_seen  (overflows_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver: random stalls, a no-stall stretch, or one long hold-off
	initial begin
		rsp_ready   = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (rsp_mode == RSP_HOLD) begin
				if (hold_cycles < HOLD_LEN) begin
					rsp_ready <= 1'b0;
					hold_cycles++;
				end else begin
					rsp_ready <= 1'b1;
				end
			end else begin
				hold_cycles = 0;
				if (rsp_mode == RSP_ALWAYS)
					rsp_ready <= 1'b1;
				else
					rsp_ready <= ($urandom_range(0, 99) >= 34);
			end
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 32'h7fffffff;
		else if (roll < 10)
			return 32'h80000000;
		else if (roll < 18)
			return $urandom_range(0, 15) - 8;
		return $urandom;
	endfunction

	function automatic logic [PRI_W-1:0] pick_priority();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return PRI_W'($urandom_range(0, 3));
		else if (roll < 48)
			return 8'd0;
		else if (roll < 56)
			return 8'd255;
		else if (roll < 70)
			return PRI_W'($urandom_range(120, 135));
		return PRI_W'($urandom_range(0, 255));
	endfunction

	task automatic offer_item(input logic kind, input logic [VAL_W-1:0] v,
			input logic [PRI_W-1:0] p);
		int gap;
		if (sender_idles && $urandom_range(0, 99) < 34) begin
			gap = $urandom_range(1, 4);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		req_type      <= kind;
		item_value    <= v;
		item_priority <= p;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_sent++;
	endtask

	initial begin
		int phase;
		int phase_len;
		int insert_pct;
		int k;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_type      = REQ_INSERT;
		item_value    = '0;
		item_priority = '0;
		rsp_mode      = RSP_RANDOM;
		sender_idles  = 1'b1;
		items_sent    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// delete from empty, extreme values and priorities, ties, fill, drop, four deletes
		offer_item(REQ_DELETE, 32'h12345678, 8'hff);
		offer_item(REQ_INSERT, 32'h7fffffff, 8'd255);
		offer_item(REQ_INSERT, 32'h80000000, 8'd0);
		offer_item(REQ_INSERT, 32'hffffffff, 8'd128);
		offer_item(REQ_INSERT, 32'h00000000, 8'd128);
		for (k = 0; k < 12; k++)
			offer_item(REQ_INSERT, $urandom, 8'((k * 37) % 256));
		offer_item(REQ_INSERT, 32'h5a5a5a5a, 8'd0);
		repeat (4)
			offer_item(REQ_DELETE, $urandom, 8'($urandom));

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			phase_len    = $urandom_range(20, 80);
			insert_pct   = 50;
			sender_idles = 1'b1;
			case ($urandom_range(0, 3))
				0: insert_pct = 90;
				1: insert_pct = 15;
				2: insert_pct = 50;
				default: insert_pct = 60;
			endcase
			if (phase == 3) begin
				phase_len    = 200;
				sender_idles = 1'b0;
				rsp_mode     <= RSP_ALWAYS;
			end else if (phase == 6) begin
				phase_len    = 48;
				insert_pct   = 70;
				sender_idles = 1'b0;
				rsp_mode     <= RSP_HOLD;
			end else begin
				rsp_mode <= RSP_RANDOM;
			end
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < insert_pct)
					offer_item(REQ_INSERT, pick_value(), pick_priority());
				else
					offer_item(REQ_DELETE, $urandom, 8'($urandom));
			end
			phase++;
		end
		req_valid <= 1'b0;
		rsp_mode  <= RSP_RANDOM;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d items: %0d entries returned, %0d empty deletes, %0d inserts dropped",
			items_sent, pops_seen, underflows_seen, overflows_seen);
		$display("phases mixed fill, drain and balanced traffic, one stall-free stretch and one long hold-off");
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sorted_priority_queue.f
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
tb/sv/spq_checker.sv
tb/sv/sorted_priority_queue_test.sv
